### sv/bhm_pkg.sv
// Shared types and constants for the binned histogram with mode tracking.
// Used by bhm_div and by the top level binned_histogram_with_mode.
`timescale 1ns / 1ps

package bhm_pkg;

  // Store geometry.
  localparam int BINS       = 256;
  localparam int BIN_BITS   = $clog2(BINS);
  localparam int COUNT_BITS = 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Sample and label width.
  localparam int DATA_W = 16;

  // Divider width and iteration counter width.
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Operation codes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_LABEL = 2'd0;
  localparam logic [1:0] REG_MAX_LABEL = 2'd1;
  localparam logic [1:0] REG_STEP_SIZE = 2'd2;

  // Configuration reset values.
  localparam logic signed [DATA_W-1:0] MIN_LABEL_RST = 16'sd0;
  localparam logic signed [DATA_W-1:0] MAX_LABEL_RST = 16'sd255;
  localparam logic [DATA_W-1:0]        STEP_SIZE_RST = 16'd16;

  // Request to the divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // Response from the divider.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/binned_histogram_with_mode.sv
// Histogram engine with saturating bin counts and peak/mode tracking.
// Depends on bhm_pkg and instantiates the divider bhm_div.
`timescale 1ns / 1ps

// A transaction is accepted when start is high and busy is low; its result
// appears on the result ports for exactly one cycle with done high, and the
// receiver cannot stall it. An add raises done after the bit-serial divider that
// forms the bin index, a step that takes the quotient, the registered count
// memory read and the saturating update, in that order. An add whose bin falls
// beyond the store ends when the quotient is taken. A read raises done after the
// memory read and the result step. A clear, an add whose sample lies outside the
// configured range and the unused opcode raise done at the accepting edge itself,
// so their result is on the ports in the very next cycle. A new transaction may
// be started in the cycle in which done is high. The bin store is emptied at
// once by per-bin valid flags on reset, on a clear and on any write to a
// defined configuration register; no clearing pass is needed.
module binned_histogram_with_mode (
  input  logic                                clk,
  input  logic                                rst,
  // Command channel.
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode,
  input  logic signed [bhm_pkg::DATA_W-1:0]   sample,
  input  logic [7:0]                          read_index,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [bhm_pkg::DATA_W-1:0]          cfg_data,
  // Result channel.
  output logic                                done,
  output logic                                accepted,
  output logic [7:0]                          bin_index,
  output logic [bhm_pkg::COUNT_BITS-1:0]      bin_count,
  output logic [bhm_pkg::COUNT_BITS-1:0]      peak_count,
  output logic signed [bhm_pkg::DATA_W-1:0]   mode_label
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  localparam int PROD_W = bhm_pkg::BIN_BITS + bhm_pkg::DATA_W;

  logic [1:0] state;

  // Configuration registers.
  logic signed [bhm_pkg::DATA_W-1:0] min_label;
  logic signed [bhm_pkg::DATA_W-1:0] max_label;
  logic [bhm_pkg::DATA_W-1:0]        step_size;

  // Tracking state.
  logic [bhm_pkg::COUNT_BITS-1:0]    peak;
  logic signed [bhm_pkg::DATA_W-1:0] mode;
  logic [bhm_pkg::BIN_BITS-1:0]      mode_bin;
  logic [bhm_pkg::BINS-1:0]          valid;

  // Working registers for the transaction in flight.
  logic                              op_add;
  logic [bhm_pkg::BIN_BITS-1:0]      cur_bin;
  logic [bhm_pkg::DATA_W-1:0]        mode_off;

  // Count memory with registered read data.
  logic [bhm_pkg::COUNT_BITS-1:0] mem [bhm_pkg::BINS];
  logic [bhm_pkg::COUNT_BITS-1:0] mem_q;
  logic                           mem_we;

  bhm_pkg::div_req_t dv_req;
  bhm_pkg::div_rsp_t dv_rsp;

  logic                           take;
  logic                           in_range;
  logic                           cfg_hit;
  logic                           quo_ok;
  logic                           read_ok;
  logic [bhm_pkg::COUNT_BITS-1:0] c_old;
  logic [bhm_pkg::COUNT_BITS-1:0] c_new;
  logic                           new_peak;
  logic [PROD_W-1:0]              prod;

  assign take    = start && !busy;
  assign busy    = (state != ST_IDLE);
  assign cfg_hit = cfg_we && (cfg_index == bhm_pkg::REG_MIN_LABEL ||
                              cfg_index == bhm_pkg::REG_MAX_LABEL ||
                              cfg_index == bhm_pkg::REG_STEP_SIZE);

  // A sample is binned only with a nonzero step and inside [min, max].
  assign in_range = (step_size != '0) && (sample >= min_label) && (sample <= max_label);

  // The divider starts on an accepted add that lies in range.
  assign dv_req.start    = take && (opcode == bhm_pkg::OP_ADD) && in_range;
  assign dv_req.dividend = bhm_pkg::DATA_W'(sample - min_label);
  assign dv_req.divisor  = step_size;

  bhm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dv_req),
    .rsp (dv_rsp)
  );

  assign quo_ok  = 32'(dv_rsp.quotient) < bhm_pkg::BINS;
  assign read_ok = 32'(read_index) < bhm_pkg::BINS;

  // Saturating increment and peak test on the fetched count.
  assign c_old    = valid[cur_bin] ? mem_q : '0;
  assign c_new    = (c_old == bhm_pkg::COUNT_MAX) ? c_old : c_old + 1'b1;
  assign new_peak = (c_new > peak) || ((c_new == peak) && (cur_bin < mode_bin));
  assign mem_we   = (state == ST_UPD) && op_add;

  // Bin label offset, registered in the read state ahead of its use in the update state.
  assign prod = PROD_W'(cur_bin) * PROD_W'(step_size);

  // Count memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_bin] <= c_new;
    end
    mem_q <= mem[cur_bin];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_label <= bhm_pkg::MIN_LABEL_RST;
      max_label <= bhm_pkg::MAX_LABEL_RST;
      step_size <= bhm_pkg::STEP_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bhm_pkg::REG_MIN_LABEL: min_label <= $signed(cfg_data);
        bhm_pkg::REG_MAX_LABEL: max_label <= $signed(cfg_data);
        bhm_pkg::REG_STEP_SIZE: step_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, tracking state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      valid    <= '0;
      peak     <= '0;
      mode     <= '0;
      mode_bin <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_hit) begin
        valid    <= '0;
        peak     <= '0;
        mode     <= '0;
        mode_bin <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            case (opcode)
              bhm_pkg::OP_ADD: begin
                op_add <= 1'b1;
                if (in_range) begin
                  state <= ST_DIV;
                end else begin
                  done      <= 1'b1;
                  accepted  <= 1'b0;
                  bin_index <= '0;
                  bin_count <= '0;
                end
              end
              bhm_pkg::OP_CLEAR: begin
                valid     <= '0;
                peak      <= '0;
                mode      <= '0;
                mode_bin  <= '0;
                done      <= 1'b1;
                accepted  <= 1'b1;
                bin_index <= '0;
                bin_count <= '0;
              end
              bhm_pkg::OP_READ: begin
                op_add    <= 1'b0;
                cur_bin   <= bhm_pkg::BIN_BITS'(read_index);
                bin_index <= read_index;
                if (read_ok) begin
                  state <= ST_READ;
                end else begin
                  done      <= 1'b1;
                  accepted  <= 1'b0;
                  bin_count <= '0;
                end
              end
              default: begin
                done      <= 1'b1;
                accepted  <= 1'b0;
                bin_index <= '0;
                bin_count <= '0;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (dv_rsp.done) begin
            if (quo_ok) begin
              cur_bin <= bhm_pkg::BIN_BITS'(dv_rsp.quotient);
              state   <= ST_READ;
            end else begin
              state     <= ST_IDLE;
              done      <= 1'b1;
              accepted  <= 1'b0;
              bin_index <= '0;
              bin_count <= '0;
            end
          end
        end
        ST_READ: begin
          mode_off <= prod[bhm_pkg::DATA_W-1:0];
          state    <= ST_UPD;
        end
        ST_UPD: begin
          state     <= ST_IDLE;
          done      <= 1'b1;
          accepted  <= 1'b1;
          bin_index <= 8'(cur_bin);
          if (op_add) begin
            bin_count      <= c_new;
            valid[cur_bin] <= 1'b1;
            if (new_peak) begin
              peak     <= c_new;
              mode_bin <= cur_bin;
              mode     <= min_label + $signed(mode_off);
            end
          end else begin
            bin_count <= c_old;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign peak_count = peak;
  assign mode_label = mode;

  // The result strobe always lands in a cycle where a new command can be taken.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An empty store has no mode.
  a_empty_mode: assert property (@(posedge clk) disable iff (rst)
    (peak == '0) |-> (mode == '0))
    else $error("mode label set with zero peak");

  // No bin count ever reported above the tracked peak.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (bin_count <= peak_count))
    else $error("bin count above peak");

  // The divider only finishes while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    dv_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

endmodule

### sv/bhm_div.sv
// Restoring unsigned divider that retires one quotient bit per clock.
// Depends on bhm_pkg for the width and the request and response structs.
`timescale 1ns / 1ps

module bhm_div (
  input  logic              clk,
  input  logic              rst,
  input  bhm_pkg::div_req_t req,
  output bhm_pkg::div_rsp_t rsp
);

  logic                          running;
  logic [bhm_pkg::DIV_CNT_W-1:0] cnt;
  logic [bhm_pkg::DIV_W-1:0]     rem;
  logic [bhm_pkg::DIV_W-1:0]     quo;
  logic [bhm_pkg::DIV_W-1:0]     divisor;
  logic                          done;

  // Trial subtraction of the divisor from the shifted partial remainder.
  logic [bhm_pkg::DIV_W:0]   shifted;
  logic [bhm_pkg::DIV_W+1:0] trial;
  logic                      fits;

  assign shifted = {rem, quo[bhm_pkg::DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};
  assign fits    = !trial[bhm_pkg::DIV_W+1];

  // Control: load on start, count iterations, pulse done after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == bhm_pkg::DIV_CNT_W'(bhm_pkg::DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: one shift and conditional subtract per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (running) begin
      rem <= fits ? trial[bhm_pkg::DIV_W-1:0] : shifted[bhm_pkg::DIV_W-1:0];
      quo <= {quo[bhm_pkg::DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### dv/binned_histogram_with_mode_tb.sv
// Self-checking testbench for binned_histogram_with_mode: a directed table, then random phases.
// Each random phase has its own bin settings; checks use the table or an in-bench predictor.
// Depends on bhm_pkg and on the binned_histogram_with_mode RTL.
`timescale 1ns / 1ps

module binned_histogram_with_mode_tb;
  import bhm_pkg::*;

  // Codes the package leaves undefined.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE  = 2'd3;

  // Items per random phase and settle time after the last result.
  localparam int PHASE_ITEMS = 280;
  localparam int SETTLE      = 30;

  typedef struct packed {
    logic                     acc;
    logic [7:0]               idx;
    logic [COUNT_BITS-1:0]    cnt;
    logic [COUNT_BITS-1:0]    peak;
    logic signed [DATA_W-1:0] mode;
  } hist_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One directed row: a transaction or a register write (code holds the register index).
  typedef struct packed {
    row_kind_t    kind;
    logic [1:0]   code;
    logic [15:0]  val;
    logic [7:0]   ridx;
    logic         typed;
    hist_result_t want;
  } dir_row_t;

  // Settings of one random phase; rnd picks random bounds and step instead.
  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] step;
    logic        rnd;
    logic [6:0]  idle;
  } phase_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               opcode;
  logic signed [DATA_W-1:0] sample;
  logic [7:0]               read_index;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [DATA_W-1:0]        cfg_data;
  logic                     done;
  logic                     accepted;
  logic [7:0]               bin_index;
  logic [COUNT_BITS-1:0]    bin_count;
  logic [COUNT_BITS-1:0]    peak_count;
  logic signed [DATA_W-1:0] mode_label;

  binned_histogram_with_mode dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .sample     (sample),
    .read_index (read_index),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .accepted   (accepted),
    .bin_index  (bin_index),
    .bin_count  (bin_count),
    .peak_count (peak_count),
    .mode_label (mode_label)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of the bins, peak, mode and bin settings.
  logic [COUNT_BITS-1:0]    bin_store [BINS];
  logic [COUNT_BITS-1:0]    peak_q;
  logic signed [DATA_W-1:0] mode_q;
  int unsigned              mode_bin_q;
  int                       lo_label;
  int                       hi_label;
  int unsigned              bin_width;

  hist_result_t expected_results [$];
  int           errors;
  int           send_idle_pct;

  function automatic void empty_bins();
    for (int i = 0; i < BINS; i++) bin_store[i] = '0;
    peak_q     = '0;
    mode_q     = '0;
    mode_bin_q = 0;
  endfunction

  // A write to a defined register changes the binning and empties the store.
  function automatic void apply_reg(input logic [1:0] idx, input logic [15:0] data);
    bit hit;
    hit = 1'b1;
    case (idx)
      REG_MIN_LABEL: lo_label  = int'($signed(data));
      REG_MAX_LABEL: hi_label  = int'($signed(data));
      REG_STEP_SIZE: bin_width = int'(data);
      default:       hit = 1'b0;
    endcase
    if (hit) empty_bins();
  endfunction

  // Expected result of one transaction; updates the predictor state.
  function automatic hist_result_t predict_histogram(input logic [1:0] op,
                                                     input logic [15:0] smp,
                                                     input logic [7:0] ridx);
    hist_result_t r;
    int           s;
    int unsigned  b;
    logic [COUNT_BITS-1:0] c;
    r = '0;
    s = int'($signed(smp));
    case (op)
      OP_ADD: begin
        if (bin_width != 0 && s >= lo_label && s <= hi_label) begin
          b = int'(s - lo_label) / bin_width;
          if (b < BINS) begin
            c = bin_store[b];
            if (c != COUNT_MAX) c = c + 1'b1;
            bin_store[b] = c;
            // Ties keep the lower bin as the mode.
            if (c > peak_q || (c == peak_q && b < mode_bin_q)) begin
              peak_q     = c;
              mode_bin_q = b;
              mode_q     = 16'(lo_label + int'(b * bin_width));
            end
            r.acc = 1'b1;
            r.idx = b[7:0];
            r.cnt = c;
          end
        end
      end
      OP_CLEAR: begin
        empty_bins();
        r.acc = 1'b1;
      end
      OP_READ: begin
        r.idx = ridx;
        if (int'(ridx) < BINS) begin
          r.acc = 1'b1;
          r.cnt = bin_store[ridx];
        end
      end
      default: ;
    endcase
    r.peak = peak_q;
    r.mode = mode_q;
    return r;
  endfunction

  // Sends one transaction after a random gap and records its expected result.
  task automatic issue(input logic [1:0] op, input logic [15:0] smp, input logic [7:0] ridx,
                       input logic typed, input hist_result_t typed_res);
    int           gap;
    hist_result_t predicted;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    sample     <= smp;
    read_index <= ridx;
    do @(posedge clk); while (busy);
    predicted = predict_histogram(op, smp, ridx);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Stops sending and waits for every outstanding result.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    wait_idle();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  // Result checker: every done transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    hist_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (accepted !== want.acc) begin
          $error("accepted: expected %0d, got %0d", want.acc, accepted);
          errors++;
        end
        if (bin_index !== want.idx) begin
          $error("bin_index: expected %0d, got %0d", want.idx, bin_index);
          errors++;
        end
        if (bin_count !== want.cnt) begin
          $error("bin_count: expected %0d, got %0d", want.cnt, bin_count);
          errors++;
        end
        if (peak_count !== want.peak) begin
          $error("peak_count: expected %0d, got %0d", want.peak, peak_count);
          errors++;
        end
        if (mode_label !== want.mode) begin
          $error("mode_label: expected %0d, got %0d", want.mode, mode_label);
          errors++;
        end
      end
    end
  end

  // Directed table: extremes, every opcode, ties, dropped samples, register corner cases.
  dir_row_t directed_rows [$] = '{
    // After reset: empty store, default bins of width 16 over 0..255.
    '{ROW_ITEM, OP_READ,   16'h0000, 8'd0,   1'b1, '{1'b1, 8'd0,   32'd0, 32'd0, 16'h0000}},
    '{ROW_ITEM, OP_UNUSED, 16'h7FFF, 8'hFF,  1'b1, '{1'b0, 8'd0,   32'd0, 32'd0, 16'h0000}},
    '{ROW_ITEM, OP_ADD,    16'h8000, 8'd0,   1'b1, '{1'b0, 8'd0,   32'd0, 32'd0, 16'h0000}},
    '{ROW_ITEM, OP_ADD,    16'h7FFF, 8'd0,   1'b1, '{1'b0, 8'd0,   32'd0, 32'd0, 16'h0000}},
    '{ROW_ITEM, OP_ADD,    16'h0000, 8'd0,   1'b1, '{1'b1, 8'd0,   32'd1, 32'd1, 16'h0000}},
    '{ROW_ITEM, OP_ADD,    16'h00FF, 8'd0,   1'b1, '{1'b1, 8'd15,  32'd1, 32'd1, 16'h0000}},
    '{ROW_ITEM, OP_ADD,    16'h00FF, 8'd0,   1'b1, '{1'b1, 8'd15,  32'd2, 32'd2, 16'd240}},
    '{ROW_ITEM, OP_ADD,    16'h0100, 8'd0,   1'b1, '{1'b0, 8'd0,   32'd0, 32'd2, 16'd240}},
    '{ROW_ITEM, OP_READ,   16'h0000, 8'd15,  1'b1, '{1'b1, 8'd15,  32'd2, 32'd2, 16'd240}},
    '{ROW_ITEM, OP_READ,   16'hFFFF, 8'd255, 1'b1, '{1'b1, 8'd255, 32'd0, 32'd2, 16'd240}},
    '{ROW_ITEM, OP_ADD,    16'h0010, 8'd0,   1'b1, '{1'b1, 8'd1,   32'd1, 32'd2, 16'd240}},
    '{ROW_ITEM, OP_CLEAR,  16'h1234, 8'd7,   1'b1, '{1'b1, 8'd0,   32'd0, 32'd0, 16'h0000}},
    '{ROW_ITEM, OP_READ,   16'h0000, 8'd15,  1'b1, '{1'b1, 8'd15,  32'd0, 32'd0, 16'h0000}},
    // Zero bin width accepts nothing.
    '{ROW_REG,  REG_STEP_SIZE, 16'h0000, 8'd0, 1'b0, '0},
    '{ROW_ITEM, OP_ADD,    16'h0005, 8'd0,   1'b1, '{1'b0, 8'd0,   32'd0, 32'd0, 16'h0000}},
    // Full 16-bit range with unit bins: samples past bin 255 fall beyond the store.
    '{ROW_REG,  REG_STEP_SIZE, 16'h0001, 8'd0, 1'b0, '0},
    '{ROW_REG,  REG_MIN_LABEL, 16'h8000, 8'd0, 1'b0, '0},
    '{ROW_REG,  REG_MAX_LABEL, 16'h7FFF, 8'd0, 1'b0, '0},
    '{ROW_ITEM, OP_ADD,    16'h8000, 8'd0,   1'b1, '{1'b1, 8'd0,   32'd1, 32'd1, 16'h8000}},
    '{ROW_ITEM, OP_ADD,    16'h80FF, 8'd0,   1'b1, '{1'b1, 8'd255, 32'd1, 32'd1, 16'h8000}},
    '{ROW_ITEM, OP_ADD,    16'h8100, 8'd0,   1'b1, '{1'b0, 8'd0,   32'd0, 32'd1, 16'h8000}},
    '{ROW_ITEM, OP_ADD,    16'h7FFF, 8'd0,   1'b1, '{1'b0, 8'd0,   32'd0, 32'd1, 16'h8000}},
    '{ROW_ITEM, OP_ADD,    16'h80FF, 8'd0,   1'b1, '{1'b1, 8'd255, 32'd2, 32'd2, 16'h80FF}},
    // A write to an undefined register index leaves the store alone.
    '{ROW_REG,  REG_NONE,  16'hFFFF, 8'd0,   1'b0, '0},
    '{ROW_ITEM, OP_READ,   16'h0000, 8'd255, 1'b1, '{1'b1, 8'd255, 32'd2, 32'd2, 16'h80FF}},
    // Empty range: min above max.
    '{ROW_REG,  REG_MIN_LABEL, 16'h0064, 8'd0, 1'b0, '0},
    '{ROW_REG,  REG_MAX_LABEL, 16'h0032, 8'd0, 1'b0, '0},
    '{ROW_ITEM, OP_ADD,    16'h004B, 8'd0,   1'b1, '{1'b0, 8'd0,   32'd0, 32'd0, 16'h0000}},
    '{ROW_ITEM, OP_ADD,    16'h0064, 8'd0,   1'b1, '{1'b0, 8'd0,   32'd0, 32'd0, 16'h0000}},
    // Widest bins: the mode label wraps to 16 bits, a lower bin wins the tie.
    '{ROW_REG,  REG_STEP_SIZE, 16'hFFFF, 8'd0, 1'b0, '0},
    '{ROW_REG,  REG_MIN_LABEL, 16'h8000, 8'd0, 1'b0, '0},
    '{ROW_REG,  REG_MAX_LABEL, 16'h7FFF, 8'd0, 1'b0, '0},
    '{ROW_ITEM, OP_ADD,    16'h7FFF, 8'd0,   1'b0, '0},
    '{ROW_ITEM, OP_ADD,    16'h8000, 8'd0,   1'b0, '0},
    '{ROW_ITEM, OP_READ,   16'h0000, 8'd1,   1'b0, '0}
  };

  // Random phases; the first three run with 12 percent sender idling, then 83, then none.
  phase_t phases [$] = '{
    '{16'h0000, 16'h00FF, 16'd16,    1'b0, 7'd12},
    '{16'h8000, 16'h7FFF, 16'd256,   1'b0, 7'd12},
    '{16'hFF9C, 16'h0064, 16'd1,     1'b0, 7'd12},
    '{16'h03E8, 16'h7FFF, 16'd1,     1'b0, 7'd83},
    '{16'h0005, 16'h0005, 16'hFFFF,  1'b0, 7'd83},
    '{16'h0000, 16'h0000, 16'd0,     1'b1, 7'd0},
    '{16'h8000, 16'h7FFF, 16'd255,   1'b0, 7'd0}
  };

  // Stimulus and end of run.
  initial begin
    logic [1:0]  op;
    logic [15:0] smp;
    logic [7:0]  ridx;
    logic [15:0] lo_w;
    logic [15:0] hi_w;
    logic [15:0] step_w;
    int          pick;
    int          span;
    int          nbins;
    int          lo_i;
    int          drain_cycles;

    rst           = 1'b1;
    start         = 1'b0;
    opcode        = OP_ADD;
    sample        = '0;
    read_index    = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_MIN_LABEL;
    cfg_data      = '0;
    errors        = 0;
    send_idle_pct = 12;
    lo_label      = int'(MIN_LABEL_RST);
    hi_label      = int'(MAX_LABEL_RST);
    bin_width     = int'(STEP_SIZE_RST);
    empty_bins();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG)
        write_reg(directed_rows[i].code, directed_rows[i].val);
      else
        issue(directed_rows[i].code, directed_rows[i].val, directed_rows[i].ridx,
              directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part.
    foreach (phases[p]) begin
      send_idle_pct = int'(phases[p].idle);
      if (phases[p].rnd) begin
        lo_w   = 16'($urandom);
        lo_i   = int'($signed(lo_w));
        span   = $urandom_range(0, 3000);
        hi_w   = (lo_i + span > 32767) ? 16'h7FFF : 16'(lo_i + span);
        step_w = 16'($urandom_range(1, 32));
      end else begin
        lo_w   = phases[p].lo;
        hi_w   = phases[p].hi;
        step_w = phases[p].step;
      end
      write_reg(REG_MIN_LABEL, lo_w);
      write_reg(REG_MAX_LABEL, hi_w);
      write_reg(REG_STEP_SIZE, step_w);
      nbins = (hi_label >= lo_label) ? (hi_label - lo_label) / int'(bin_width) : 0;
      if (nbins > 255) nbins = 255;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 72)      op = OP_ADD;
        else if (pick < 88) op = OP_READ;
        else if (pick < 92) op = OP_CLEAR;
        else if (pick < 95) op = OP_UNUSED;
        else                op = 2'($urandom);

        // Most samples land inside the range and near the bins; the rest are raw noise.
        if (hi_label >= lo_label && $urandom_range(0, 99) < 80) begin
          span = hi_label - lo_label;
          if (longint'(span) > longint'(bin_width) * 260) span = int'(bin_width) * 260;
          smp = 16'(lo_label + int'($urandom_range(0, span)));
        end else begin
          smp = 16'($urandom);
        end

        if ($urandom_range(0, 99) < 60) ridx = 8'($urandom_range(0, nbins));
        else                             ridx = 8'($urandom);

        issue(op, smp, ridx, 1'b0, '0);

        // Now and then hold off until the block has drained.
        if ($urandom_range(0, 99) == 0) wait_idle();
      end
    end

    // Drain and settle.
    wait_idle();
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, well above a run where every item waits out the longest sender gap.
  initial begin
    #50000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
